/* rtl/core/antialiased_circle_rasterizer_unit_defines.svh */
// assertion macros used by the circle rasterizer checker
`ifndef ANTIALIASED_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH
`define ANTIALIASED_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define ACR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define ACR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/acr_pkg.sv */
// types, constants and the candidate table of the circle rasterizer
`default_nettype none
package acr_pkg;

    localparam int ACR_COORD_BITS = 12;
    localparam int ACR_FRAC_BITS  = 8;

    localparam int NUM_CAND   = 16;
    localparam int CAND_IDX_W = 4;
    localparam logic [CAND_IDX_W-1:0] LAST_CAND = CAND_IDX_W'(NUM_CAND - 1);

    // bit positions in the result tuser
    localparam int USER_VIS  = 0;
    localparam int USER_DONE = 1;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OPND_X,
        OPND_X1,
        OPND_Y
    } t_opnd;

    typedef struct packed {
        logic  x_sub;
        t_opnd x_sel;
        logic  y_sub;
        t_opnd y_sel;
        logic  far;
    } t_cand;

    // near/far pairs for the low-angle then high-angle octants
    function automatic t_cand cand_entry(input logic [CAND_IDX_W-1:0] idx);
        t_cand c;
        c = '{x_sub: 1'b0, x_sel: OPND_X, y_sub: 1'b0, y_sel: OPND_Y, far: 1'b0};
        case (idx)
            4'd0:  c = '{1'b0, OPND_X,  1'b0, OPND_Y,  1'b0};
            4'd1:  c = '{1'b0, OPND_X1, 1'b0, OPND_Y,  1'b1};
            4'd2:  c = '{1'b0, OPND_X,  1'b1, OPND_Y,  1'b0};
            4'd3:  c = '{1'b0, OPND_X1, 1'b1, OPND_Y,  1'b1};
            4'd4:  c = '{1'b1, OPND_X,  1'b0, OPND_Y,  1'b0};
            4'd5:  c = '{1'b1, OPND_X1, 1'b0, OPND_Y,  1'b1};
            4'd6:  c = '{1'b1, OPND_X,  1'b1, OPND_Y,  1'b0};
            4'd7:  c = '{1'b1, OPND_X1, 1'b1, OPND_Y,  1'b1};
            4'd8:  c = '{1'b0, OPND_Y,  1'b0, OPND_X,  1'b0};
            4'd9:  c = '{1'b0, OPND_Y,  1'b0, OPND_X1, 1'b1};
            4'd10: c = '{1'b1, OPND_Y,  1'b0, OPND_X,  1'b0};
            4'd11: c = '{1'b1, OPND_Y,  1'b0, OPND_X1, 1'b1};
            4'd12: c = '{1'b0, OPND_Y,  1'b1, OPND_X,  1'b0};
            4'd13: c = '{1'b0, OPND_Y,  1'b1, OPND_X1, 1'b1};
            4'd14: c = '{1'b1, OPND_Y,  1'b1, OPND_X,  1'b0};
            4'd15: c = '{1'b1, OPND_Y,  1'b1, OPND_X1, 1'b1};
            default: c = '{1'b0, OPND_X, 1'b0, OPND_Y, 1'b0};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/acr_sub_unit.sv */
// shared subtract and compare unit used for the clamp test and the division steps
`default_nettype none
module acr_sub_unit
    import acr_pkg::*;
#(
    parameter int WIDTH = ACR_COORD_BITS + 2
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic      [WIDTH-1:0] o_diff,
    output logic                  o_ge
);

    logic [WIDTH:0] full;

    assign full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = full[WIDTH-1:0];
    assign o_ge   = ~full[WIDTH];

endmodule
`default_nettype wire

/* rtl/core/acr_cand_gen.sv */
// pixel candidate coordinates and visibility for one table index
`default_nettype none
module acr_cand_gen
    import acr_pkg::*;
#(
    parameter int COORD_BITS = ACR_COORD_BITS
) (
    input  wire logic [CAND_IDX_W-1:0] i_idx,
    input  wire logic [COORD_BITS-1:0] i_cx,
    input  wire logic [COORD_BITS-1:0] i_cy,
    input  wire logic [COORD_BITS-1:0] i_wx,
    input  wire logic [COORD_BITS:0]   i_wy,
    output logic      [COORD_BITS:0]   o_px,
    output logic      [COORD_BITS:0]   o_py,
    output logic                       o_vis,
    output logic                       o_far
);

    localparam int W = COORD_BITS + 1;

    t_cand          cand;
    logic [W-1:0]   opnd_x;
    logic [W-1:0]   opnd_y;
    logic [W:0]     sum_x;
    logic [W:0]     sum_y;

    function automatic logic [W-1:0] pick(input t_opnd sel,
                                          input logic [COORD_BITS-1:0] wx,
                                          input logic [W-1:0] wy);
        logic [W-1:0] v;
        case (sel)
            OPND_X:  v = {1'b0, wx};
            OPND_X1: v = {1'b0, wx} + W'(1);
            OPND_Y:  v = wy;
            default: v = wy;
        endcase
        return v;
    endfunction

    assign cand   = cand_entry(i_idx);
    assign opnd_x = pick(cand.x_sel, i_wx, i_wy);
    assign opnd_y = pick(cand.y_sel, i_wx, i_wy);

    // one extra bit holds the sign of a difference
    assign sum_x = cand.x_sub ? ({2'b00, i_cx} - {1'b0, opnd_x})
                              : ({2'b00, i_cx} + {1'b0, opnd_x});
    assign sum_y = cand.y_sub ? ({2'b00, i_cy} - {1'b0, opnd_y})
                              : ({2'b00, i_cy} + {1'b0, opnd_y});

    assign o_vis = ~((cand.x_sub & sum_x[W]) | (cand.y_sub & sum_y[W]));
    assign o_px  = o_vis ? sum_x[W-1:0] : '0;
    assign o_py  = o_vis ? sum_y[W-1:0] : '0;
    assign o_far = cand.far;

endmodule
`default_nettype wire

/* rtl/core/antialiased_circle_rasterizer_unit.sv */
// antialiased circle octant walker: sequencer, walk state and output register
// one step per start word, or per continue word while a walk is active: accept, clamp, then
// the divider (skipped when radius is zero or error >= 2*radius), then 16 result words, one
// per cycle while the output is not stalled; the fraction is a restoring division
// a continue word taken while no walk is active is ignored
// synchronous active-low reset clears the sequencer, the walking flag and the output valid
`default_nettype none
module antialiased_circle_rasterizer_unit
    import acr_pkg::*;
#(
    parameter int COORD_BITS = ACR_COORD_BITS,
    parameter int FRAC_BITS  = ACR_FRAC_BITS,
    localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * (COORD_BITS + 1) + FRAC_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // circle column, circle row, radius
    input  wire logic [IN_W-1:0]       i_s_axis_tdata,
    // op
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // pixel_x, pixel_y, intensity
    output logic      [OUT_W-1:0]      o_m_axis_tdata,
    // visible, done_res
    output logic      [OUT_USER_W-1:0] o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);

    localparam int W     = COORD_BITS + 1;
    localparam int UW    = COORD_BITS + 2;
    localparam int CNT_W = $clog2(FRAC_BITS);

    t_state r_state, n_state;

    logic [COORD_BITS-1:0] r_cx, n_cx;
    logic [COORD_BITS-1:0] r_cy, n_cy;
    logic [COORD_BITS-1:0] r_rad, n_rad;
    logic [COORD_BITS-1:0] r_walk_x, n_walk_x;
    logic [W-1:0]          r_walk_y, n_walk_y;
    logic [W-1:0]          r_err, n_err;
    logic                  r_walking, n_walking;
    logic [W-1:0]          r_rem, n_rem;
    logic [FRAC_BITS-1:0]  r_frac, n_frac;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CAND_IDX_W-1:0] r_k, n_k;
    logic                  r_out_valid, n_out_valid;
    logic [OUT_W-1:0]      r_out_data, n_out_data;
    logic [OUT_USER_W-1:0] r_out_user, n_out_user;
    logic                  r_out_last, n_out_last;

    logic [UW-1:0]         alu_a;
    logic [UW-1:0]         alu_b;
    logic [UW-1:0]         alu_diff;
    logic                  alu_ge;

    logic [W:0]            step_inc;
    logic                  short_err;
    logic [W-1:0]          x_less_y;
    logic [W-1:0]          err_short;
    logic [W-1:0]          err_long;
    logic                  walk_done;

    logic [COORD_BITS:0]   cand_px;
    logic [COORD_BITS:0]   cand_py;
    logic                  cand_vis;
    logic                  cand_far;
    logic [FRAC_BITS-1:0]  cand_int;
    logic                  out_load;

    acr_sub_unit #(
        .WIDTH (UW)
    ) u_sub (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_ge   (alu_ge)
    );

    acr_cand_gen #(
        .COORD_BITS (COORD_BITS)
    ) u_cand (
        .i_idx (r_k),
        .i_cx  (r_cx),
        .i_cy  (r_cy),
        .i_wx  (r_walk_x),
        .i_wy  (r_walk_y),
        .o_px  (cand_px),
        .o_py  (cand_py),
        .o_vis (cand_vis),
        .o_far (cand_far)
    );

    // divisor is 2*radius in both uses
    assign alu_a = (r_state == ST_DIV) ? {r_rem, 1'b0} : {1'b0, r_err};
    assign alu_b = {1'b0, r_rad, 1'b0};

    // next walk position, computed from the held walk state
    assign step_inc  = {r_walk_y, 1'b1};
    assign short_err = {1'b0, r_err} < step_inc;
    assign x_less_y  = {1'b0, r_walk_x} - r_walk_y - W'(1);
    assign err_short = r_err + {x_less_y[W-2:0], 1'b0};
    assign err_long  = r_err - step_inc[W-1:0];
    assign walk_done = short_err ? (({1'b0, r_walk_y} + (W+1)'(1)) >= {2'b00, r_walk_x})
                                 : (r_walk_y >= {1'b0, r_walk_x});

    assign cand_int = cand_far ? r_frac : ~r_frac;
    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_walking   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_walking   <= n_walking;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_rad      <= n_rad;
        r_walk_x   <= n_walk_x;
        r_walk_y   <= n_walk_y;
        r_err      <= n_err;
        r_rem      <= n_rem;
        r_frac     <= n_frac;
        r_cnt      <= n_cnt;
        r_k        <= n_k;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rad       = r_rad;
        n_walk_x    = r_walk_x;
        n_walk_y    = r_walk_y;
        n_err       = r_err;
        n_walking   = r_walking;
        n_rem       = r_rem;
        n_frac      = r_frac;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_m_axis_tready;

        case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    if (i_s_axis_tuser) begin
                        n_cx      = i_s_axis_tdata[COORD_BITS-1:0];
                        n_cy      = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
                        n_rad     = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
                        n_walk_x  = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
                        n_walk_y  = '0;
                        n_err     = '0;
                        n_walking = 1'b1;
                        n_state   = ST_CLAMP;
                    end else if (r_walking && (r_walk_y <= {1'b0, r_walk_x})) begin
                        n_state = ST_CLAMP;
                    end else begin
                        n_walking = 1'b0;
                    end
                end
            end
            ST_CLAMP: begin
                n_k   = '0;
                n_cnt = '0;
                n_rem = r_err;
                if (r_rad == '0) begin
                    n_frac  = '0;
                    n_state = ST_EMIT;
                end else if (alu_ge) begin
                    // error at or above 2*radius saturates the fraction
                    n_frac  = '1;
                    n_state = ST_EMIT;
                end else begin
                    n_frac  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = alu_ge ? alu_diff[W-1:0] : alu_a[W-1:0];
                n_frac = {r_frac[FRAC_BITS-2:0], alu_ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_out_valid          = 1'b1;
                    n_out_data           = OUT_W'({cand_int, cand_py, cand_px});
                    n_out_user           = '0;
                    n_out_user[USER_VIS]  = cand_vis;
                    n_out_user[USER_DONE] = walk_done;
                    n_out_last           = (r_k == LAST_CAND);
                    n_k                  = r_k + CAND_IDX_W'(1);
                    if (r_k == LAST_CAND) begin
                        n_err     = short_err ? err_short : err_long;
                        n_walk_x  = short_err ? (r_walk_x - COORD_BITS'(1)) : r_walk_x;
                        n_walk_y  = r_walk_y + W'(1);
                        n_walking = !walk_done;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

/* rtl/core/acr_checker.sv */
// port-level checks for the circle rasterizer, bound to the top level
`default_nettype none
`include "antialiased_circle_rasterizer_unit_defines.svh"
module acr_checker
    import acr_pkg::*;
#(
    parameter int COORD_BITS = ACR_COORD_BITS,
    parameter int FRAC_BITS  = ACR_FRAC_BITS,
    localparam int OUT_W = ((2 * (COORD_BITS + 1) + FRAC_BITS + 7) / 8) * 8
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_axis_tvalid,
    input wire logic                  o_s_axis_tready,
    input wire logic                  i_s_axis_tuser,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_W-1:0]      o_m_axis_tdata,
    input wire logic [OUT_USER_W-1:0] o_m_axis_tuser,
    input wire logic                  o_m_axis_tlast
);

    logic in_word;

    assign in_word = i_s_axis_tvalid && o_s_axis_tready;

    // a start word always begins a step, so the input side must close
    `ACR_ASSERT_NEXT(a_start_busy, in_word && i_s_axis_tuser, !o_s_axis_tready,
        "start word did not begin a step")

    // a dropped candidate carries zero coordinates
    `ACR_ASSERT_NOW(a_hidden_zero, o_m_axis_tvalid && !o_m_axis_tuser[USER_VIS],
        o_m_axis_tdata[2*COORD_BITS+1:0] == '0, "hidden candidate has nonzero coordinates")

    // a stalled result word holds its value
    `ACR_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast),
        "stalled result word changed")

endmodule

bind antialiased_circle_rasterizer_unit acr_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_acr_checker (.*);
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench of the antialiased circle rasterizer: directed table, then random walks
`timescale 1ns / 100ps
`default_nettype none
module tb_top
    import acr_pkg::*;
();

    localparam int IN_W  = ((3 * ACR_COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2 * (ACR_COORD_BITS + 1) + ACR_FRAC_BITS + 7) / 8) * 8;
    localparam int FULL_COVER = (1 << ACR_FRAC_BITS) - 1;

    localparam logic OP_CONT  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam int DIR_ROWS       = 24;
    localparam int RAND_STEPS     = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4 * (ACR_FRAC_BITS + 18);
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [12:0] px;
        logic [12:0] py;
        logic [7:0]  inten;
        logic        vis;
        logic        last;
        logic        done;
    } t_pixel;

    typedef struct {
        logic        op;
        logic [11:0] cx;
        logic [11:0] cy;
        logic [11:0] r;
        bit          typed;
        int          n_exp;
        t_pixel      first;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic [IN_W-1:0] s_data = '0;
    logic s_user = 1'b0;
    logic m_ready = 1'b0;

    wire logic                  s_ready;
    wire logic                  m_valid;
    wire logic [OUT_W-1:0]      m_data;
    wire logic [OUT_USER_W-1:0] m_user;
    wire logic                  m_last;

    antialiased_circle_rasterizer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // circle column, circle row, radius
        .i_s_axis_tuser  (s_user),   // op
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // pixel_x, pixel_y, intensity
        .o_m_axis_tuser  (m_user),   // visible, done_res
        .o_m_axis_tlast  (m_last)
    );

    // walk state mirrored by the predictor
    logic [11:0] trk_x = '0;
    logic [12:0] trk_y = '0;
    logic [12:0] trk_err = '0;
    logic [11:0] ctr_x = '0;
    logic [11:0] ctr_y = '0;
    logic [11:0] ctr_r = '0;
    logic        trk_active = 1'b0;

    t_pixel pixel_q [$];
    int     errors = 0;
    int     pixels_checked = 0;
    int     circles = 0;
    int     idle_words = 0;
    bit     hold_req = 1'b0;
    bit     send_calm = 1'b0;
    bit     sink_calm = 1'b0;

    t_stim_row dir_tab [DIR_ROWS] = '{
        // continue right after reset: nothing happens
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b1, 0,  '0},
        // zero radius at the origin: one step, ends the walk
        '{OP_START, 12'd0,    12'd0,    12'd0,    1'b1, 16,
          '{13'd0, 13'd0, 8'd255, 1'b1, 1'b0, 1'b1}},
        // continue after the walk ended, fields ignored
        '{OP_CONT,  12'd4095, 12'd4095, 12'd4095, 1'b1, 0,  '0},
        '{OP_START, 12'd4095, 12'd4095, 12'd4095, 1'b1, 16,
          '{13'd8190, 13'd4095, 8'd255, 1'b1, 1'b0, 1'b0}},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        // restart while the big circle is still walking
        '{OP_START, 12'd0,    12'd0,    12'd4095, 1'b1, 16,
          '{13'd4095, 13'd0, 8'd255, 1'b1, 1'b0, 1'b0}},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_START, 12'd2048, 12'd1024, 12'd1,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        // center near the corner: negative coordinates drop out
        '{OP_START, 12'd3,    12'd2,    12'd7,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_START, 12'd100,  12'd200,  12'd2,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_START, 12'd4095, 12'd0,    12'd3,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0},
        '{OP_CONT,  12'd0,    12'd0,    12'd0,    1'b0, 0,  '0}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one octant step: queues the sixteen expected candidates, returns their count (zero when no walk is active)
    function automatic int trace_octant_step(input logic op, input logic [11:0] cx,
                                             input logic [11:0] cy, input logic [11:0] r);
        int     wx, wy, we, frac, diff, nx, ny, nerr;
        int     ox, oy, px, py, icx, icy;
        logic   done, vis, far, xs, ys;
        t_pixel p;
        if (op == OP_START) begin
            ctr_x = cx;
            ctr_y = cy;
            ctr_r = r;
            trk_x = r;
            trk_y = '0;
            trk_err = '0;
            trk_active = 1'b1;
        end
        if (!trk_active || trk_y > trk_x) begin
            trk_active = 1'b0;
            return 0;
        end
        wx = int'(trk_x);
        wy = int'(trk_y);
        we = int'(trk_err);
        icx = int'(ctr_x);
        icy = int'(ctr_y);
        frac = 0;
        if (ctr_r != 0) begin
            frac = (we << ACR_FRAC_BITS) / (2 * int'(ctr_r));
            if (frac > FULL_COVER) frac = FULL_COVER;
        end
        diff = 2 * wy + 1;
        nx = wx;
        ny = wy + 1;
        if (we < diff) begin
            nerr = (we + 2 * wx - 1 - diff) & 32'h1FFF;
            nx = nx - 1;
        end else begin
            nerr = we - diff;
        end
        done = (ny > nx);
        for (int k = 0; k < NUM_CAND; k++) begin
            far = k[0];
            // low-angle pairs walk along x, high-angle pairs have x and y swapped
            if (k < 8) begin
                ox = wx + int'(far);
                oy = wy;
                xs = k[2];
                ys = k[1];
            end else begin
                ox = wy;
                oy = wx + int'(far);
                xs = k[1];
                ys = k[2];
            end
            px = xs ? icx - ox : icx + ox;
            py = ys ? icy - oy : icy + oy;
            vis = (px >= 0) && (py >= 0);
            p.px = vis ? px[12:0] : 13'd0;
            p.py = vis ? py[12:0] : 13'd0;
            p.inten = far ? frac[7:0] : 8'(FULL_COVER - frac);
            p.vis = vis;
            p.last = (k == NUM_CAND - 1);
            p.done = done;
            pixel_q.push_back(p);
        end
        trk_err = nerr[12:0];
        trk_x = nx[11:0];
        trk_y = ny[12:0];
        if (done) trk_active = 1'b0;
        return NUM_CAND;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int sel;
        sel = $urandom_range(0, 19);
        if (calm || sel < 11) return 0;
        if (sel < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one word, wait for it to be taken, then predict and maybe pause
    task automatic offer_word(input logic op, input logic [11:0] cx, input logic [11:0] cy,
                              input logic [11:0] r, output int n);
        int gap;
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= IN_W'({r, cy, cx});
        do @(posedge i_clk); while (!s_ready);
        n = trace_octant_step(op, cx, cy, r);
        if (op == OP_START) circles++;
        if (n == 0) idle_words++;
        if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
                gap = pick_gap(sink_calm);
                if (gap == 0) begin
                    m_ready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_pixel want;
        if (i_rst_n && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected result word, actual tdata %h tuser %b tlast %b",
                         $time, m_data, m_user, m_last);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                pixels_checked++;
                check_field("pixel_x",   int'(want.px),    int'(m_data[12:0]));
                check_field("pixel_y",   int'(want.py),    int'(m_data[25:13]));
                check_field("intensity", int'(want.inten), int'(m_data[33:26]));
                check_field("visible",   int'(want.vis),   int'(m_user[USER_VIS]));
                check_field("done",      int'(want.done),  int'(m_user[USER_DONE]));
                check_field("last",      int'(want.last),  int'(m_last));
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: watchdog expired with %0d results outstanding", $time, pixel_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          n;
        int          rand_steps;
        int          sel;
        int          conts;
        logic [11:0] cx, cy, rad;
        bit          big;
        rand_steps = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            offer_word(dir_tab[i].op, dir_tab[i].cx, dir_tab[i].cy, dir_tab[i].r, n);
            if (dir_tab[i].typed) begin
                if (dir_tab[i].n_exp == 0) begin
                    repeat (n) void'(pixel_q.pop_back());
                end else if (n > 0) begin
                    pixel_q[pixel_q.size() - n] = dir_tab[i].first;
                end
            end
        end

        // the sender keeps offering while the result side holds off
        hold_req = 1'b1;
        while (rand_steps < RAND_STEPS) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                // noise word with random fields
                offer_word(OP_CONT, 12'($urandom), 12'($urandom), 12'($urandom), n);
                if (n > 0) rand_steps++;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 20) cx = 12'($urandom_range(0, 30));
                else if (sel < 30) cx = 12'($urandom_range(4065, 4095));
                else cx = 12'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 20) cy = 12'($urandom_range(0, 30));
                else if (sel < 30) cy = 12'($urandom_range(4065, 4095));
                else cy = 12'($urandom);
                sel = $urandom_range(0, 99);
                big = (sel >= 85);
                if (sel < 85) rad = 12'($urandom_range(0, 24));
                else if (sel < 95) rad = 12'($urandom_range(25, 300));
                else rad = 12'($urandom);
                offer_word(OP_START, cx, cy, rad, n);
                rand_steps++;
                // big circles are cut short by the next start
                conts = big ? $urandom_range(0, 5) :
                        ($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : 4096);
                while (conts > 0 && trk_active && rand_steps < RAND_STEPS) begin
                    offer_word(OP_CONT, 12'($urandom), 12'($urandom), 12'($urandom), n);
                    rand_steps++;
                    conts--;
                end
            end
        end
        s_valid <= 1'b0;

        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d circles, %0d ignored continue words, %0d pixel candidates checked",
                 circles, idle_words, pixels_checked);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", errors);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
